@@ rtl/pvrs_pkg.sv @@
// ----------------------------------------------------------------------------
// pvrs_pkg
// Shared types, register indexes and helpers for the PCM volume ramp unit.
// ----------------------------------------------------------------------------
package pvrs_pkg;

	// Hard limit on the ramp block length, in frames.
	localparam int MAX_FRAMES = 4096;

	// Configuration register indexes.
	localparam logic [1:0] REG_TARGET_VOLUME    = 2'd0;
	localparam logic [1:0] REG_FRAMES_PER_BLOCK = 2'd1;
	localparam logic [1:0] REG_STEREO_MODE      = 2'd2;

	localparam logic [14:0] TARGET_VOLUME_RST    = 15'd4096;
	localparam logic [12:0] FRAMES_PER_BLOCK_RST = 13'd1024;
	localparam logic        STEREO_MODE_RST      = 1'b1;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               block_end;
	} out_beat_t;

	// Frame as classified by the front end.
	typedef struct packed {
		in_beat_t samples;
		logic     first;
		logic     last;
	} queue_entry_t;

	// Divider request / response.
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [14:0] magnitude;
		logic [12:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quotient;
	} div_rsp_t;

	// Effective block length: zero reads as one, clamp to MAX_FRAMES.
	function automatic logic [12:0] eff_frames(input logic [12:0] fpb);
		logic [12:0] f;
		begin
			f = fpb;
			if (fpb == 13'd0) begin
				f = 13'd1;
			end else if (fpb > 13'(MAX_FRAMES)) begin
				f = 13'(MAX_FRAMES);
			end
			return f;
		end
	endfunction

endpackage

@@ rtl/pcm_volume_ramp_saturate_unit.sv @@
// ----------------------------------------------------------------------------
// pcm_volume_ramp_saturate_unit
// Linear 4.12 volume ramp over blocks of PCM frames with 16-bit saturation.
// ----------------------------------------------------------------------------
// Use:
//   frame_valid/frame_ready/frame carry one PCM frame (left, right) per beat.
//   result_valid/result_ready/result return one scaled frame per input beat,
//   in order, with block_end set on the last frame of each ramp block.
//   cfg_we/cfg_idx/cfg_data write target_volume (0), frames_per_block (1)
//   and stereo_mode (2); write only while no frame is in flight.
// Timing:
//   Inside a block the unit moves one frame per cycle while result_ready is
//   high; a frame accepted with an empty queue is registered in the queue,
//   then in the result register. The first frame of each block waits for
//   the ramp step, computed by a one-bit-per-cycle divider. Frames keep
//   being accepted into the queue during that time, until it is full.
// Reset:
//   arst_n clears the ramp (previous volume zero, position at block start)
//   and loads the register defaults: unity target, 1024 frames, stereo.
// Stall:
//   When result_ready is low the result register holds; the queue fills
//   and frame_ready drops once QUEUE_DEPTH frames are waiting.
// ----------------------------------------------------------------------------
module pcm_volume_ramp_saturate_unit #(
	parameter int QUEUE_DEPTH = 4   // 2..32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [14:0]         cfg_data,
	input  logic                frame_valid,
	output logic                frame_ready,
	input  pvrs_pkg::in_beat_t  frame,
	output logic                result_valid,
	input  logic                result_ready,
	output pvrs_pkg::out_beat_t result
);

	// configuration registers
	logic [14:0] target_volume_q;
	logic [12:0] frames_per_block_q;
	logic        stereo_mode_q;

	// front -> queue -> back
	logic                   push;
	pvrs_pkg::queue_entry_t push_data;
	logic                   queue_full;
	logic                   pop;
	logic                   head_valid;
	pvrs_pkg::queue_entry_t head;

	// back <-> divider
	pvrs_pkg::div_req_t div_req;
	pvrs_pkg::div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_volume_q    <= pvrs_pkg::TARGET_VOLUME_RST;
			frames_per_block_q <= pvrs_pkg::FRAMES_PER_BLOCK_RST;
			stereo_mode_q      <= pvrs_pkg::STEREO_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pvrs_pkg::REG_TARGET_VOLUME:    target_volume_q    <= cfg_data;
				pvrs_pkg::REG_FRAMES_PER_BLOCK: frames_per_block_q <= cfg_data[12:0];
				pvrs_pkg::REG_STEREO_MODE:      stereo_mode_q      <= cfg_data[0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// Front: accept and tag block start / end from the frame counter.
	pvrs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.frames_per_block (frames_per_block_q),
		.frame_valid      (frame_valid),
		.frame_ready      (frame_ready),
		.frame            (frame),
		.queue_full       (queue_full),
		.push             (push),
		.push_data        (push_data)
	);

	// Decoupling queue; lets the front keep taking beats during step setup.
	pvrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: ramp accumulator, gain multiply, saturate, result register.
	pvrs_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.target_volume    (target_volume_q),
		.frames_per_block (frames_per_block_q),
		.stereo_mode      (stereo_mode_q),
		.head_valid       (head_valid),
		.head             (head),
		.pop              (pop),
		.div_req          (div_req),
		.div_rsp          (div_rsp),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.result           (result)
	);

	// Step divider, used once per block.
	pvrs_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

@@ rtl/pvrs_front.sv @@
// ----------------------------------------------------------------------------
// pvrs_front
// Accepts frames and tags them with block start / block end flags.
// ----------------------------------------------------------------------------
module pvrs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [12:0]            frames_per_block,
	input  logic                   frame_valid,
	output logic                   frame_ready,
	input  pvrs_pkg::in_beat_t     frame,
	input  logic                   queue_full,
	output logic                   push,
	output pvrs_pkg::queue_entry_t push_data
);

	logic [12:0] pos_q;
	logic [13:0] pos_inc;
	logic [12:0] eff;
	logic        last;

	assign eff         = pvrs_pkg::eff_frames(frames_per_block);
	assign pos_inc     = {1'b0, pos_q} + 14'd1;
	assign last        = pos_inc >= {1'b0, eff};
	assign frame_ready = !queue_full;
	assign push        = frame_valid && frame_ready;

	assign push_data.samples = frame;
	assign push_data.first   = (pos_q == 13'd0);
	assign push_data.last    = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 13'd0;
		end else if (push) begin
			pos_q <= last ? 13'd0 : pos_inc[12:0];
		end
	end

endmodule

@@ rtl/pvrs_queue.sv @@
// ----------------------------------------------------------------------------
// pvrs_queue
// Small FIFO of classified frames between front and back end.
// ----------------------------------------------------------------------------
module pvrs_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pvrs_pkg::queue_entry_t push_data,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output pvrs_pkg::queue_entry_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pvrs_pkg::queue_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/pvrs_divider.sv @@
// ----------------------------------------------------------------------------
// pvrs_divider
// Radix-2 restoring divider for the ramp step: (+/-mag << 16) / divisor.
// ----------------------------------------------------------------------------
module pvrs_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  pvrs_pkg::div_req_t  req,
	output pvrs_pkg::div_rsp_t  rsp
);

	localparam int QW = 31;   // 15-bit magnitude followed by 16 zero bits

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [4:0]    cnt_q;
	logic [12:0]   div_q;
	logic [12:0]   rem_q;
	logic [QW-1:0] quo_q;   // dividend bits shift out the top, quotient in at the bottom

	logic [13:0] trial;
	logic        ge;
	logic [13:0] diff;
	logic [31:0] quo_ext;

	assign trial   = {rem_q, quo_q[QW-1]};
	assign ge      = trial >= {1'b0, div_q};
	assign diff    = trial - {1'b0, div_q};
	assign quo_ext = {1'b0, quo_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? $signed(-quo_ext) : $signed(quo_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.neg;
				div_q  <= req.divisor;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= {req.magnitude, 16'd0};
			end else if (busy_q) begin
				rem_q <= ge ? diff[12:0] : trial[12:0];
				quo_q <= {quo_q[QW-2:0], ge};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/pvrs_back.sv @@
// ----------------------------------------------------------------------------
// pvrs_back
// Ramp state, step setup at block start, gain multiply and output register.
// ----------------------------------------------------------------------------
module pvrs_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [14:0]            target_volume,
	input  logic [12:0]            frames_per_block,
	input  logic                   stereo_mode,
	input  logic                   head_valid,
	input  pvrs_pkg::queue_entry_t head,
	output logic                   pop,
	output pvrs_pkg::div_req_t     div_req,
	input  pvrs_pkg::div_rsp_t     div_rsp,
	output logic                   result_valid,
	input  logic                   result_ready,
	output pvrs_pkg::out_beat_t    result
);

	typedef enum logic {
		ST_RUN,
		ST_DIV
	} state_t;

	state_t              state_q;
	logic [14:0]         prev_q;
	logic [31:0]         acc_q;
	logic [31:0]         step_q;
	logic                primed_q;   // step/acc loaded for the frame at the head
	logic                out_valid_q;
	pvrs_pkg::out_beat_t out_q;

	logic signed [15:0] gain;
	logic signed [31:0] prod_l;
	logic signed [31:0] prod_r;
	logic signed [15:0] diff;
	logic               out_free;
	logic               fire;

	function automatic logic [15:0] sat16(input logic signed [31:0] p);
		logic [19:0] s;
		begin
			s = p[31:12];
			if (s[19:15] == 5'b00000 || s[19:15] == 5'b11111) begin
				return s[15:0];
			end else if (s[19]) begin
				return 16'h8000;
			end else begin
				return 16'h7FFF;
			end
		end
	endfunction

	assign gain   = acc_q[31:16];
	assign prod_l = head.samples.left_sample * gain;
	assign prod_r = head.samples.right_sample * gain;
	assign diff   = $signed({1'b0, target_volume}) - $signed({1'b0, prev_q});

	assign out_free = !out_valid_q || result_ready;
	assign fire     = (state_q == ST_RUN) && head_valid && (!head.first || primed_q) && out_free;
	assign pop      = fire;

	assign div_req.start     = (state_q == ST_RUN) && head_valid && head.first && !primed_q;
	assign div_req.neg       = diff[15];
	assign div_req.magnitude = diff[15] ? 15'(-diff) : diff[14:0];
	assign div_req.divisor   = pvrs_pkg::eff_frames(frames_per_block);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			prev_q      <= '0;
			acc_q       <= '0;
			step_q      <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						step_q   <= div_rsp.quotient;
						acc_q    <= {1'b0, prev_q, 16'd0};
						primed_q <= 1'b1;
						state_q  <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase

			if (fire) begin
				out_valid_q     <= 1'b1;
				out_q.left_out  <= sat16(prod_l);
				out_q.right_out <= stereo_mode ? sat16(prod_r) : 16'd0;
				out_q.block_end <= head.last;
				acc_q           <= acc_q + step_q;
				primed_q        <= 1'b0;
				if (head.last) begin
					prev_q <= target_volume;
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/pvrs_checker.sv @@
// ----------------------------------------------------------------------------
// pvrs_checker
// Port-level checks for the PCM volume ramp unit, bound to the top level.
// ----------------------------------------------------------------------------
module pvrs_checker #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic [1:0]          cfg_idx,
	input logic [14:0]         cfg_data,
	input logic                frame_valid,
	input logic                frame_ready,
	input logic                result_valid,
	input logic                result_ready,
	input pvrs_pkg::out_beat_t result
);

	localparam int OUT_W = $clog2(QUEUE_DEPTH + 2) + 1;

	logic [OUT_W-1:0] outstanding_q;
	logic             stereo_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = frame_valid && frame_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			stereo_q      <= pvrs_pkg::STEREO_MODE_RST;
		end else begin
			if (in_acc && !out_acc) begin
				outstanding_q <= outstanding_q + 1'b1;
			end else if (out_acc && !in_acc) begin
				outstanding_q <= outstanding_q - 1'b1;
			end
			if (cfg_we && cfg_idx == pvrs_pkg::REG_STEREO_MODE) begin
				stereo_q <= cfg_data[0];
			end
		end
	end

	// a pending beat is not withdrawn
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	// no result without a frame behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == '0 |-> !result_valid)
		else $error("result presented with no frame outstanding");

	// queue plus result register bound the frames in flight
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> outstanding_q <= OUT_W'(QUEUE_DEPTH))
		else $error("frame accepted beyond internal capacity");

	// mono mode zeroes the right channel
	a_mono_right: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !stereo_q |-> result.right_out == 16'sd0)
		else $error("right_out nonzero in mono mode");

endmodule

bind pcm_volume_ramp_saturate_unit pvrs_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_pvrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_idx      (cfg_idx),
	.cfg_data     (cfg_data),
	.frame_valid  (frame_valid),
	.frame_ready  (frame_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
